// ----- sv/rigid_body_verlet_integrator_top_assert.svh -----
// Assertion macros for the rigid body Verlet integrator checker.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef RIGID_BODY_VERLET_INTEGRATOR_TOP_ASSERT_SVH
`define RIGID_BODY_VERLET_INTEGRATOR_TOP_ASSERT_SVH

// Implication into the next cycle, switched off while reset is applied.
`define RBVI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication into the next cycle that also holds across reset.
`define RBVI_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rbvi_pkg.sv -----
// Shared types, codes and fixed-point helpers for the rigid body Verlet integrator.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package rbvi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UPC_W     = 6;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESET   = 2'd1;
  localparam logic [1:0] OP_PREDICT = 2'd2;
  localparam logic [1:0] OP_CORRECT = 2'd3;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_VEL   = 2'd1;
  localparam logic [1:0] MODE_FORCE = 2'd2;
  localparam logic [1:0] MODE_FIXED = 2'd3;

  localparam logic [2:0] CFG_MOTION_MODE = 3'd0;
  localparam logic [2:0] CFG_TIME_STEP   = 3'd1;
  localparam logic [2:0] CFG_GRAVITY_X   = 3'd2;
  localparam logic [2:0] CFG_GRAVITY_Y   = 3'd3;
  localparam logic [2:0] CFG_INV_MASS    = 3'd4;
  localparam logic [2:0] CFG_INV_INERTIA = 3'd5;
  localparam logic [2:0] CFG_DAMPING     = 3'd6;

  localparam logic [1:0]         RST_MOTION_MODE = MODE_FIXED;
  localparam logic [30:0]        RST_TIME_STEP   = 31'd65;
  localparam logic signed [31:0] RST_GRAVITY_X   = 32'sd0;
  localparam logic signed [31:0] RST_GRAVITY_Y   = -32'sd642908;
  localparam logic [30:0]        RST_INV_MASS    = 31'd65536;
  localparam logic [30:0]        RST_INV_INERTIA = 31'd65536;
  localparam logic [30:0]        RST_DAMPING     = 31'd0;

  localparam logic [UPC_W-1:0] ENTRY_LOAD    = 6'd0;
  localparam logic [UPC_W-1:0] ENTRY_RESET   = 6'd6;
  localparam logic [UPC_W-1:0] ENTRY_PREDICT = 6'd17;
  localparam logic [UPC_W-1:0] ENTRY_CORRECT = 6'd33;

  typedef enum logic [4:0] {
    S_ZERO, S_POSX, S_POSY, S_ANG, S_VELX, S_VELY, S_SPIN, S_ACCX,
    S_ACCY, S_RACC, S_FSX, S_FSY, S_MSUM, S_DT, S_H, S_H2,
    S_GX, S_GY, S_IMASS, S_IINERT, S_DAMP, S_IN_PX, S_IN_PY, S_IN_ANG,
    S_IN_VX, S_IN_VY, S_IN_SPIN, S_IN_FX, S_IN_FY, S_IN_MOM, S_PROD, S_TMP
  } src_t;

  typedef enum logic [3:0] {
    D_NONE, D_POSX, D_POSY, D_ANG, D_VELX, D_VELY, D_SPIN, D_ACCX,
    D_ACCY, D_RACC, D_FSX, D_FSY, D_MSUM, D_H2, D_TMP
  } dst_t;

  typedef enum logic [1:0] {
    A_NOP, A_ADD, A_SUB
  } alu_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_FIXED, C_VEL, C_NOT_FORCE, C_NOT_FREE, C_PASSIVE, C_FORCE
  } cond_t;

  typedef struct packed {
    logic             mul_en;
    src_t             mul_a;
    src_t             mul_b;
    alu_t             alu;
    src_t             alu_a;
    src_t             alu_b;
    dst_t             dst;
    cond_t            cond;
    logic             fin;
    logic [UPC_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]         motion_mode;
    logic [30:0]        time_step;
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic [30:0]        inv_mass;
    logic [30:0]        inv_inertia;
    logic [30:0]        damping;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin_rate;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] moment;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] rot;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
  } motion_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic sub);
    logic signed [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] prod_sat(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p >>> FRAC_BITS;
    if (q > 64'sh0000_0000_7FFF_FFFF) begin
      prod_sat = 32'sh7FFF_FFFF;
    end else if (q < -64'sh0000_0000_8000_0000) begin
      prod_sat = 32'sh8000_0000;
    end else begin
      prod_sat = q[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/rbvi_ucode_rom.sv -----
// Microcode store of the integrator: one control word per program step.
// Depends on rbvi_pkg for the control word layout and the operand codes.
`default_nettype none

module rbvi_ucode_rom (
  input  logic [rbvi_pkg::UPC_W-1:0] addr,
  output rbvi_pkg::ctrl_t            word
);

  function automatic rbvi_pkg::ctrl_t cw(input logic me,
                                         input rbvi_pkg::src_t ma,
                                         input rbvi_pkg::src_t mb,
                                         input rbvi_pkg::alu_t op,
                                         input rbvi_pkg::src_t aa,
                                         input rbvi_pkg::src_t ab,
                                         input rbvi_pkg::dst_t d,
                                         input rbvi_pkg::cond_t c,
                                         input logic f,
                                         input logic [rbvi_pkg::UPC_W-1:0] t);
    rbvi_pkg::ctrl_t w;
    w.mul_en = me;
    w.mul_a  = ma;
    w.mul_b  = mb;
    w.alu    = op;
    w.alu_a  = aa;
    w.alu_b  = ab;
    w.dst    = d;
    w.cond   = c;
    w.fin    = f;
    w.tgt    = t;
    cw = w;
  endfunction

  localparam logic [rbvi_pkg::UPC_W-1:0] NT = '0;

  always_comb begin
    unique case (addr)
      // Load.
      6'd0:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_PX, rbvi_pkg::S_ZERO, rbvi_pkg::D_POSX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd1:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_PY, rbvi_pkg::S_ZERO, rbvi_pkg::D_POSY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd2:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_ANG, rbvi_pkg::S_ZERO, rbvi_pkg::D_ANG,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd3:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_VX, rbvi_pkg::S_ZERO, rbvi_pkg::D_VELX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd4:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_VY, rbvi_pkg::S_ZERO, rbvi_pkg::D_VELY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd5:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_SPIN, rbvi_pkg::S_ZERO, rbvi_pkg::D_SPIN,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      // Reset of the step accumulators.
      6'd6:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_MSUM,
                       rbvi_pkg::C_NOT_FORCE, 1'b0, 6'd12);
      6'd7:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_RACC,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd8:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_FX, rbvi_pkg::S_ZERO, rbvi_pkg::D_FSX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd9:  word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_IN_FY, rbvi_pkg::S_ZERO, rbvi_pkg::D_FSY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd10: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd11: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCY,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      6'd12: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_RACC,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd13: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_FSX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd14: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_FSY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd15: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_GX, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd16: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_GY, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCY,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      // Predict.
      6'd17: word = cw(1'b1, rbvi_pkg::S_H, rbvi_pkg::S_DT, rbvi_pkg::A_NOP,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_NONE,
                       rbvi_pkg::C_FIXED, 1'b1, NT);
      6'd18: word = cw(1'b1, rbvi_pkg::S_VELX, rbvi_pkg::S_DT, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_H2,
                       rbvi_pkg::C_VEL, 1'b0, 6'd31);
      6'd19: word = cw(1'b1, rbvi_pkg::S_ACCX, rbvi_pkg::S_H2, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_TMP,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd20: word = cw(1'b1, rbvi_pkg::S_ACCX, rbvi_pkg::S_H, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_TMP, rbvi_pkg::S_PROD, rbvi_pkg::D_TMP,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd21: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_POSX, rbvi_pkg::S_TMP, rbvi_pkg::D_POSX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd22: word = cw(1'b1, rbvi_pkg::S_VELY, rbvi_pkg::S_DT, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_VELX, rbvi_pkg::S_PROD, rbvi_pkg::D_VELX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd23: word = cw(1'b1, rbvi_pkg::S_ACCY, rbvi_pkg::S_H2, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_TMP,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd24: word = cw(1'b1, rbvi_pkg::S_ACCY, rbvi_pkg::S_H, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_TMP, rbvi_pkg::S_PROD, rbvi_pkg::D_TMP,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd25: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_POSY, rbvi_pkg::S_TMP, rbvi_pkg::D_POSY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd26: word = cw(1'b1, rbvi_pkg::S_SPIN, rbvi_pkg::S_DT, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_VELY, rbvi_pkg::S_PROD, rbvi_pkg::D_VELY,
                       rbvi_pkg::C_NOT_FREE, 1'b1, NT);
      6'd27: word = cw(1'b1, rbvi_pkg::S_RACC, rbvi_pkg::S_H2, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_TMP,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd28: word = cw(1'b1, rbvi_pkg::S_RACC, rbvi_pkg::S_H, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_TMP, rbvi_pkg::S_PROD, rbvi_pkg::D_TMP,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd29: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_ANG, rbvi_pkg::S_TMP, rbvi_pkg::D_ANG,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd30: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_SPIN, rbvi_pkg::S_PROD, rbvi_pkg::D_SPIN,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      6'd31: word = cw(1'b1, rbvi_pkg::S_VELY, rbvi_pkg::S_DT, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_POSX, rbvi_pkg::S_PROD, rbvi_pkg::D_POSX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd32: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_POSY, rbvi_pkg::S_PROD, rbvi_pkg::D_POSY,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      // Correct.
      6'd33: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_FSX, rbvi_pkg::S_IN_FX, rbvi_pkg::D_FSX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd34: word = cw(1'b1, rbvi_pkg::S_FSX, rbvi_pkg::S_IMASS, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_FSY, rbvi_pkg::S_IN_FY, rbvi_pkg::D_FSY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd35: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_MSUM, rbvi_pkg::S_IN_MOM, rbvi_pkg::D_MSUM,
                       rbvi_pkg::C_PASSIVE, 1'b1, NT);
      6'd36: word = cw(1'b1, rbvi_pkg::S_FSY, rbvi_pkg::S_IMASS, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCX,
                       rbvi_pkg::C_FORCE, 1'b0, 6'd43);
      6'd37: word = cw(1'b1, rbvi_pkg::S_ACCX, rbvi_pkg::S_H, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd38: word = cw(1'b1, rbvi_pkg::S_ACCY, rbvi_pkg::S_H, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_VELX, rbvi_pkg::S_PROD, rbvi_pkg::D_VELX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd39: word = cw(1'b1, rbvi_pkg::S_MSUM, rbvi_pkg::S_IINERT, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_VELY, rbvi_pkg::S_PROD, rbvi_pkg::D_VELY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd40: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_RACC,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd41: word = cw(1'b1, rbvi_pkg::S_RACC, rbvi_pkg::S_H, rbvi_pkg::A_NOP,
                       rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_NONE,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd42: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_SPIN, rbvi_pkg::S_PROD, rbvi_pkg::D_SPIN,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      6'd43: word = cw(1'b1, rbvi_pkg::S_DAMP, rbvi_pkg::S_VELX, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_PROD, rbvi_pkg::S_ZERO, rbvi_pkg::D_ACCY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd44: word = cw(1'b1, rbvi_pkg::S_DAMP, rbvi_pkg::S_VELY, rbvi_pkg::A_SUB,
                       rbvi_pkg::S_ACCX, rbvi_pkg::S_PROD, rbvi_pkg::D_ACCX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd45: word = cw(1'b1, rbvi_pkg::S_ACCX, rbvi_pkg::S_H, rbvi_pkg::A_SUB,
                       rbvi_pkg::S_ACCY, rbvi_pkg::S_PROD, rbvi_pkg::D_ACCY,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd46: word = cw(1'b1, rbvi_pkg::S_ACCY, rbvi_pkg::S_H, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_VELX, rbvi_pkg::S_PROD, rbvi_pkg::D_VELX,
                       rbvi_pkg::C_NEVER, 1'b0, NT);
      6'd47: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_ADD,
                       rbvi_pkg::S_VELY, rbvi_pkg::S_PROD, rbvi_pkg::D_VELY,
                       rbvi_pkg::C_ALWAYS, 1'b1, NT);
      default: word = cw(1'b0, rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::A_NOP,
                         rbvi_pkg::S_ZERO, rbvi_pkg::S_ZERO, rbvi_pkg::D_NONE,
                         rbvi_pkg::C_ALWAYS, 1'b1, NT);
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/rbvi_sequencer.sv -----
// Step counter of the integrator: dispatches on the opcode, follows jumps and ends programs.
// Depends on rbvi_pkg for the control word, the condition codes and the entry points.
`default_nettype none

module rbvi_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 opcode,
  input  logic [1:0]                 motion_mode,
  input  rbvi_pkg::ctrl_t            word,
  output logic [rbvi_pkg::UPC_W-1:0] upc,
  output logic                       busy,
  output logic                       done
);

  logic [rbvi_pkg::UPC_W-1:0] upc_r;
  logic                       run_r;
  logic                       cond_ok;
  logic [rbvi_pkg::UPC_W-1:0] entry;

  always_comb begin
    unique case (word.cond)
      rbvi_pkg::C_NEVER:     cond_ok = 1'b0;
      rbvi_pkg::C_ALWAYS:    cond_ok = 1'b1;
      rbvi_pkg::C_FIXED:     cond_ok = (motion_mode == rbvi_pkg::MODE_FIXED);
      rbvi_pkg::C_VEL:       cond_ok = (motion_mode == rbvi_pkg::MODE_VEL);
      rbvi_pkg::C_NOT_FORCE: cond_ok = (motion_mode != rbvi_pkg::MODE_FORCE);
      rbvi_pkg::C_NOT_FREE:  cond_ok = (motion_mode != rbvi_pkg::MODE_FREE);
      rbvi_pkg::C_PASSIVE:   cond_ok = (motion_mode == rbvi_pkg::MODE_VEL) ||
                                       (motion_mode == rbvi_pkg::MODE_FIXED);
      rbvi_pkg::C_FORCE:     cond_ok = (motion_mode == rbvi_pkg::MODE_FORCE);
      default:               cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    unique case (opcode)
      rbvi_pkg::OP_LOAD:    entry = rbvi_pkg::ENTRY_LOAD;
      rbvi_pkg::OP_RESET:   entry = rbvi_pkg::ENTRY_RESET;
      rbvi_pkg::OP_PREDICT: entry = rbvi_pkg::ENTRY_PREDICT;
      default:              entry = rbvi_pkg::ENTRY_CORRECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      upc_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      upc_r <= entry;
    end else if (run_r) begin
      if (cond_ok && word.fin) begin
        run_r <= 1'b0;
      end else if (cond_ok) begin
        upc_r <= word.tgt;
      end else begin
        upc_r <= upc_r + 1'b1;
      end
    end
  end

  assign upc  = upc_r;
  assign busy = run_r;
  assign done = run_r && cond_ok && word.fin;

endmodule

`default_nettype wire

// ----- sv/rbvi_datapath.sv -----
// Datapath of the integrator: motion state, shared multiplier and saturating adder.
// Depends on rbvi_pkg for the control word, operand codes and fixed-point helpers.
`default_nettype none

module rbvi_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               exec,
  input  rbvi_pkg::ctrl_t    word,
  input  rbvi_pkg::cfg_t     cfg,
  input  rbvi_pkg::item_t    item,
  output rbvi_pkg::motion_t  motion
);

  logic signed [31:0] posx_r, posy_r, ang_r, velx_r, vely_r, spin_r;
  logic signed [31:0] accx_r, accy_r, racc_r, fsx_r, fsy_r, msum_r;
  logic signed [31:0] h2_r, tmp_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] prod_q;
  logic signed [31:0] mul_a, mul_b, alu_a, alu_b, alu_y;

  function automatic logic signed [31:0] pick(input rbvi_pkg::src_t s,
                                              input rbvi_pkg::motion_t m,
                                              input logic signed [31:0] accx,
                                              input logic signed [31:0] accy,
                                              input logic signed [31:0] racc,
                                              input logic signed [31:0] fsx,
                                              input logic signed [31:0] fsy,
                                              input logic signed [31:0] msum,
                                              input logic signed [31:0] h2,
                                              input logic signed [31:0] tmp,
                                              input logic signed [31:0] pq,
                                              input rbvi_pkg::cfg_t c,
                                              input rbvi_pkg::item_t it);
    case (s)
      rbvi_pkg::S_ZERO:    pick = '0;
      rbvi_pkg::S_POSX:    pick = m.pos_x;
      rbvi_pkg::S_POSY:    pick = m.pos_y;
      rbvi_pkg::S_ANG:     pick = m.rot;
      rbvi_pkg::S_VELX:    pick = m.vel_x;
      rbvi_pkg::S_VELY:    pick = m.vel_y;
      rbvi_pkg::S_SPIN:    pick = m.spin;
      rbvi_pkg::S_ACCX:    pick = accx;
      rbvi_pkg::S_ACCY:    pick = accy;
      rbvi_pkg::S_RACC:    pick = racc;
      rbvi_pkg::S_FSX:     pick = fsx;
      rbvi_pkg::S_FSY:     pick = fsy;
      rbvi_pkg::S_MSUM:    pick = msum;
      rbvi_pkg::S_DT:      pick = {1'b0, c.time_step};
      rbvi_pkg::S_H:       pick = {2'b00, c.time_step[30:1]};
      rbvi_pkg::S_H2:      pick = h2;
      rbvi_pkg::S_GX:      pick = c.gravity_x;
      rbvi_pkg::S_GY:      pick = c.gravity_y;
      rbvi_pkg::S_IMASS:   pick = {1'b0, c.inv_mass};
      rbvi_pkg::S_IINERT:  pick = {1'b0, c.inv_inertia};
      rbvi_pkg::S_DAMP:    pick = {1'b0, c.damping};
      rbvi_pkg::S_IN_PX:   pick = it.pos_x;
      rbvi_pkg::S_IN_PY:   pick = it.pos_y;
      rbvi_pkg::S_IN_ANG:  pick = it.angle;
      rbvi_pkg::S_IN_VX:   pick = it.vel_x;
      rbvi_pkg::S_IN_VY:   pick = it.vel_y;
      rbvi_pkg::S_IN_SPIN: pick = it.spin_rate;
      rbvi_pkg::S_IN_FX:   pick = it.force_x;
      rbvi_pkg::S_IN_FY:   pick = it.force_y;
      rbvi_pkg::S_IN_MOM:  pick = it.moment;
      rbvi_pkg::S_PROD:    pick = pq;
      rbvi_pkg::S_TMP:     pick = tmp;
      default:             pick = '0;
    endcase
  endfunction

  assign motion.pos_x = posx_r;
  assign motion.pos_y = posy_r;
  assign motion.rot   = ang_r;
  assign motion.vel_x = velx_r;
  assign motion.vel_y = vely_r;
  assign motion.spin  = spin_r;

  assign prod_q = rbvi_pkg::prod_sat(prod_r);

  always_comb begin
    mul_a = pick(word.mul_a, motion, accx_r, accy_r, racc_r, fsx_r, fsy_r, msum_r,
                 h2_r, tmp_r, prod_q, cfg, item);
    mul_b = pick(word.mul_b, motion, accx_r, accy_r, racc_r, fsx_r, fsy_r, msum_r,
                 h2_r, tmp_r, prod_q, cfg, item);
    alu_a = pick(word.alu_a, motion, accx_r, accy_r, racc_r, fsx_r, fsy_r, msum_r,
                 h2_r, tmp_r, prod_q, cfg, item);
    alu_b = pick(word.alu_b, motion, accx_r, accy_r, racc_r, fsx_r, fsy_r, msum_r,
                 h2_r, tmp_r, prod_q, cfg, item);
    alu_y = rbvi_pkg::sat_add(alu_a, alu_b, word.alu == rbvi_pkg::A_SUB);
  end

  always_ff @(posedge clk) begin
    if (exec && word.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (exec && (word.alu != rbvi_pkg::A_NOP)) begin
      case (word.dst)
        rbvi_pkg::D_H2:  h2_r  <= alu_y;
        rbvi_pkg::D_TMP: tmp_r <= alu_y;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posx_r <= '0;
      posy_r <= '0;
      ang_r  <= '0;
      velx_r <= '0;
      vely_r <= '0;
      spin_r <= '0;
      accx_r <= '0;
      accy_r <= '0;
      racc_r <= '0;
      fsx_r  <= '0;
      fsy_r  <= '0;
      msum_r <= '0;
    end else if (exec && (word.alu != rbvi_pkg::A_NOP)) begin
      case (word.dst)
        rbvi_pkg::D_POSX: posx_r <= alu_y;
        rbvi_pkg::D_POSY: posy_r <= alu_y;
        rbvi_pkg::D_ANG:  ang_r  <= alu_y;
        rbvi_pkg::D_VELX: velx_r <= alu_y;
        rbvi_pkg::D_VELY: vely_r <= alu_y;
        rbvi_pkg::D_SPIN: spin_r <= alu_y;
        rbvi_pkg::D_ACCX: accx_r <= alu_y;
        rbvi_pkg::D_ACCY: accy_r <= alu_y;
        rbvi_pkg::D_RACC: racc_r <= alu_y;
        rbvi_pkg::D_FSX:  fsx_r  <= alu_y;
        rbvi_pkg::D_FSY:  fsy_r  <= alu_y;
        rbvi_pkg::D_MSUM: msum_r <= alu_y;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/rigid_body_verlet_integrator_top.sv -----
// Each transaction runs one microcode program selected by in_opcode; the reset, predict
// and correct programs branch on the motion mode (fixed, imposed velocity, imposed force
// or free). A new transaction is accepted only once the previous program has ended and
// its result has been moved to the output register; all programs share one multiplier.
// Reset: synchronous active-low rst_n clears the motion state, loads the register defaults
// and empties the output register.
`default_nettype none

module rigid_body_verlet_integrator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_spin_rate,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_moment,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_position_x,
  output logic signed [31:0] out_position_y,
  output logic signed [31:0] out_rotation,
  output logic signed [31:0] out_velocity_x,
  output logic signed [31:0] out_velocity_y,
  output logic signed [31:0] out_rotation_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  rbvi_pkg::cfg_t             cfg_r;
  rbvi_pkg::item_t            item_r;
  rbvi_pkg::motion_t          motion;
  rbvi_pkg::motion_t          out_r;
  rbvi_pkg::ctrl_t            word;
  logic [rbvi_pkg::UPC_W-1:0] upc;
  logic                       busy;
  logic                       done;
  logic                       pend_r;
  logic                       out_valid_r;
  logic                       start;

  assign in_stall  = busy || pend_r;
  assign start     = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (start) begin
      item_r.pos_x     <= in_pos_x;
      item_r.pos_y     <= in_pos_y;
      item_r.angle     <= in_angle;
      item_r.vel_x     <= in_vel_x;
      item_r.vel_y     <= in_vel_y;
      item_r.spin_rate <= in_spin_rate;
      item_r.force_x   <= in_force_x;
      item_r.force_y   <= in_force_y;
      item_r.moment    <= in_moment;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_mode <= rbvi_pkg::RST_MOTION_MODE;
      cfg_r.time_step   <= rbvi_pkg::RST_TIME_STEP;
      cfg_r.gravity_x   <= rbvi_pkg::RST_GRAVITY_X;
      cfg_r.gravity_y   <= rbvi_pkg::RST_GRAVITY_Y;
      cfg_r.inv_mass    <= rbvi_pkg::RST_INV_MASS;
      cfg_r.inv_inertia <= rbvi_pkg::RST_INV_INERTIA;
      cfg_r.damping     <= rbvi_pkg::RST_DAMPING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rbvi_pkg::CFG_MOTION_MODE: cfg_r.motion_mode <= cfg_data[1:0];
        rbvi_pkg::CFG_TIME_STEP:   cfg_r.time_step   <= cfg_data[30:0];
        rbvi_pkg::CFG_GRAVITY_X:   cfg_r.gravity_x   <= cfg_data;
        rbvi_pkg::CFG_GRAVITY_Y:   cfg_r.gravity_y   <= cfg_data;
        rbvi_pkg::CFG_INV_MASS:    cfg_r.inv_mass    <= cfg_data[30:0];
        rbvi_pkg::CFG_INV_INERTIA: cfg_r.inv_inertia <= cfg_data[30:0];
        rbvi_pkg::CFG_DAMPING:     cfg_r.damping     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // The motion state stays put while a result is pending, so it is copied when the
  // output register frees up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pend_r && (!out_valid_r || !out_stall)) begin
        pend_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (done) begin
          pend_r <= 1'b1;
        end
        if (out_valid_r && !out_stall) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && (!out_valid_r || !out_stall)) begin
      out_r <= motion;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position_x    = out_r.pos_x;
  assign out_position_y    = out_r.pos_y;
  assign out_rotation      = out_r.rot;
  assign out_velocity_x    = out_r.vel_x;
  assign out_velocity_y    = out_r.vel_y;
  assign out_rotation_rate = out_r.spin;

  rbvi_ucode_rom u_rom (
    .addr (upc),
    .word (word)
  );

  rbvi_sequencer u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .opcode      (in_opcode),
    .motion_mode (cfg_r.motion_mode),
    .word        (word),
    .upc         (upc),
    .busy        (busy),
    .done        (done)
  );

  rbvi_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .exec   (busy),
    .word   (word),
    .cfg    (cfg_r),
    .item   (item_r),
    .motion (motion)
  );

endmodule

`default_nettype wire

// ----- sv/rbvi_checker.sv -----
// Port-level checker for the rigid body Verlet integrator and its bind to the top level.
// Depends on rigid_body_verlet_integrator_top_assert.svh for the assertion macros.
`default_nettype none

`include "rigid_body_verlet_integrator_top_assert.svh"

module rbvi_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_position_x
);

  `RBVI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  `RBVI_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "stalled result dropped")
  `RBVI_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_position_x), "stalled result changed")
  `RBVI_ASSERT_NEXT_RST(a_reset_empties, !rst_n, !out_valid, "result present after reset")

endmodule

bind rigid_body_verlet_integrator_top rbvi_checker u_rbvi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_position_x (out_position_x)
);

`default_nettype wire
